@@ design/dmx_channel_value_decoder_top_assert.svh @@
// assertion macros for the channel value decoder
// all checks are clocked on clk_i and disabled while rst_ni is low
`ifndef DMX_CHANNEL_VALUE_DECODER_TOP_ASSERT_SVH
`define DMX_CHANNEL_VALUE_DECODER_TOP_ASSERT_SVH

// same-cycle implication
`define DMXCV_ASSERT_IMP(label, cond, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (expr)) \
    else $error("dmxcv same-cycle check failed");

// next-cycle implication
`define DMXCV_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (expr)) \
    else $error("dmxcv next-cycle check failed");

`endif

@@ design/dmxcv_pkg.sv @@
`default_nettype none

package dmxcv_pkg;

  // field widths
  localparam int SLOT_W    = 9;
  localparam int BYTE_W    = 8;
  localparam int RAW_W     = 32;
  localparam int NORM_W    = 17;
  localparam int PHYS_W    = 32;
  localparam int CFG_W     = 36;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_W     = 3;

  // slots at or above this address are ignored
  localparam int UNIVERSE_SLOTS = 512;

  // fixed point
  localparam int                NORM_FRAC  = 16;
  localparam logic [NORM_W-1:0] NORM_ONE   = 17'h10000;
  localparam int                ROUND_HALF = 32768;
  localparam int                DELTA_W    = PHYS_W + 1;
  localparam int                PROD_W     = DELTA_W + NORM_W + 1;
  localparam int                DIV_CNT_W  = 5;

  // frame queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = QPTR_W + 1;

  // register reset values
  localparam logic [CNT_W-1:0]  RST_BYTE_COUNT = 3'd1;
  localparam logic [CFG_W-1:0]  RST_SOURCES    = '0;
  localparam logic [RAW_W-1:0]  RST_RANGE_FROM = 32'd0;
  localparam logic [RAW_W-1:0]  RST_RANGE_TO   = 32'd255;
  localparam logic [PHYS_W-1:0] RST_PHYS_LOW   = 32'd0;
  localparam logic [PHYS_W-1:0] RST_PHYS_HIGH  = 32'h0001_0000;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BYTE_COUNT = 3'd0,
    REG_SOURCES    = 3'd1,
    REG_RANGE_FROM = 3'd2,
    REG_RANGE_TO   = 3'd3,
    REG_PHYS_LOW   = 3'd4,
    REG_PHYS_HIGH  = 3'd5
  } reg_idx_e;

  // configuration as seen by front and back
  typedef struct packed {
    logic [CNT_W-1:0]  used_bytes;
    logic [CFG_W-1:0]  source_slots;
    logic [RAW_W-1:0]  range_from;
    logic [RAW_W-1:0]  range_to;
    logic [PHYS_W-1:0] physical_low;
    logic [PHYS_W-1:0] physical_high;
  } cfg_t;

  // one assembled frame waiting for evaluation
  typedef struct packed {
    logic [RAW_W-1:0] raw;
    logic             missing;
  } frame_t;

endpackage

`default_nettype wire

@@ design/dmxcv_slot_if.sv @@
`default_nettype none

interface dmxcv_slot_if;
  logic                          valid;
  logic                          ready;
  logic [dmxcv_pkg::SLOT_W-1:0]  slot_address;
  logic [dmxcv_pkg::BYTE_W-1:0]  slot_value;
  logic                          end_of_frame;

  modport source (output valid, output slot_address, output slot_value,
                  output end_of_frame, input ready);
  modport sink   (input valid, input slot_address, input slot_value,
                  input end_of_frame, output ready);
endinterface

`default_nettype wire

@@ design/dmxcv_result_if.sv @@
`default_nettype none

interface dmxcv_result_if;
  logic                                valid;
  logic                                ready;
  logic [dmxcv_pkg::RAW_W-1:0]         raw_word;
  logic [dmxcv_pkg::NORM_W-1:0]        normalized;
  logic signed [dmxcv_pkg::PHYS_W-1:0] physical;
  logic                                slot_missing;

  modport source (output valid, output raw_word, output normalized,
                  output physical, output slot_missing, input ready);
  modport sink   (input valid, input raw_word, input normalized,
                  input physical, input slot_missing, output ready);
endinterface

`default_nettype wire

@@ design/dmxcv_front.sv @@
`default_nettype none

module dmxcv_front #(
  parameter int MAX_BYTES = 4
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  dmxcv_slot_if.sink            slot_in,
  input  dmxcv_pkg::cfg_t       cfg_i,
  output logic                  push_valid_o,
  input  wire                   push_ready_i,
  output dmxcv_pkg::frame_t     push_data_o
);

  logic [dmxcv_pkg::BYTE_W-1:0] cap_q [MAX_BYTES];
  logic [dmxcv_pkg::BYTE_W-1:0] cap_d [MAX_BYTES];
  logic [MAX_BYTES-1:0]         seen_q;
  logic [MAX_BYTES-1:0]         seen_d;
  logic                         take;
  logic                         in_universe;
  logic [dmxcv_pkg::RAW_W-1:0]  raw;
  logic                         missing;

  // a slot is taken whenever the queue can hold a frame end
  assign slot_in.ready = push_ready_i;
  assign take          = slot_in.valid && push_ready_i;
  assign in_universe   = ({1'b0, slot_in.slot_address} <
                          (dmxcv_pkg::SLOT_W + 1)'(dmxcv_pkg::UNIVERSE_SLOTS));

  // capture the slot into every used field that names it
  always_comb begin
    cap_d  = cap_q;
    seen_d = seen_q;
    for (int k = 0; k < MAX_BYTES; k++) begin
      if (take && in_universe && (k < int'(cfg_i.used_bytes)) &&
          (cfg_i.source_slots[k*dmxcv_pkg::SLOT_W +: dmxcv_pkg::SLOT_W] ==
           slot_in.slot_address)) begin
        cap_d[k]  = slot_in.slot_value;
        seen_d[k] = 1'b1;
      end
    end
  end

  // pack captured bytes most significant first, unseen ones read zero
  always_comb begin
    logic [dmxcv_pkg::BYTE_W-1:0] b;
    raw     = '0;
    missing = 1'b0;
    b       = '0;
    for (int k = 0; k < MAX_BYTES; k++) begin
      if (k < int'(cfg_i.used_bytes)) begin
        b       = seen_d[k] ? cap_d[k] : '0;
        raw     = {raw[dmxcv_pkg::RAW_W-dmxcv_pkg::BYTE_W-1:0], b};
        missing = missing | !seen_d[k];
      end
    end
  end

  assign push_valid_o        = take && slot_in.end_of_frame;
  assign push_data_o.raw     = raw;
  assign push_data_o.missing = missing;

  // capture state, cleared after each frame end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_BYTES; k++) begin
        cap_q[k] <= '0;
      end
      seen_q <= '0;
    end else if (take && slot_in.end_of_frame) begin
      for (int k = 0; k < MAX_BYTES; k++) begin
        cap_q[k] <= '0;
      end
      seen_q <= '0;
    end else begin
      cap_q  <= cap_d;
      seen_q <= seen_d;
    end
  end

endmodule

`default_nettype wire

@@ design/dmxcv_queue.sv @@
`default_nettype none

module dmxcv_queue (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push_valid_i,
  output logic                  push_ready_o,
  input  dmxcv_pkg::frame_t     push_data_i,
  output logic                  pop_valid_o,
  input  wire                   pop_ready_i,
  output dmxcv_pkg::frame_t     pop_data_o
);

  dmxcv_pkg::frame_t               mem_q [dmxcv_pkg::QUEUE_DEPTH];
  logic [dmxcv_pkg::QPTR_W-1:0]    wr_q;
  logic [dmxcv_pkg::QPTR_W-1:0]    rd_q;
  logic [dmxcv_pkg::QCNT_W-1:0]    cnt_q;
  logic                            push;
  logic                            pop;

  assign push_ready_o = (cnt_q != dmxcv_pkg::QCNT_W'(dmxcv_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

endmodule

`default_nettype wire

@@ design/dmxcv_back.sv @@
`default_nettype none

module dmxcv_back (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  dmxcv_pkg::cfg_t       cfg_i,
  input  wire                   pop_valid_i,
  output logic                  pop_ready_o,
  input  dmxcv_pkg::frame_t     pop_data_i,
  dmxcv_result_if.source        res_out
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_SUM  = 4'b1000
  } state_e;

  localparam int RAW_W  = dmxcv_pkg::RAW_W;
  localparam int NORM_W = dmxcv_pkg::NORM_W;
  localparam int PHYS_W = dmxcv_pkg::PHYS_W;
  localparam int PROD_W = dmxcv_pkg::PROD_W;

  state_e                                 state_q, state_d;
  logic [dmxcv_pkg::DIV_CNT_W-1:0]        cnt_q, cnt_d;
  logic [RAW_W-1:0]                       raw_q, raw_d;
  logic                                   miss_q, miss_d;
  logic [RAW_W-1:0]                       span_q, span_d;
  logic [RAW_W-1:0]                       rem_q, rem_d;
  logic [NORM_W-1:0]                      quo_q, quo_d;
  logic [NORM_W-1:0]                      norm_q, norm_d;
  logic signed [dmxcv_pkg::DELTA_W-1:0]   delta_q, delta_d;
  logic signed [PROD_W-1:0]               prod_q, prod_d;
  logic                                   out_valid_q, out_valid_d;
  logic [RAW_W-1:0]                       out_raw_q, out_raw_d;
  logic [NORM_W-1:0]                      out_norm_q, out_norm_d;
  logic [PHYS_W-1:0]                      out_phys_q, out_phys_d;
  logic                                   out_miss_q, out_miss_d;

  logic [5:0]        shamt;
  logic [RAW_W-1:0]  full_scale;
  logic [RAW_W-1:0]  span_c;
  logic [RAW_W-1:0]  diff_c;
  logic [RAW_W:0]    rem2;
  logic              qbit;
  logic [NORM_W-1:0] quo_next;
  logic [NORM_W:0]   rnd;
  logic [PROD_W-1:0] sum_c;

  // span from the range, or full scale of the used bytes
  assign shamt      = 6'(RAW_W - dmxcv_pkg::BYTE_W * int'(cfg_i.used_bytes));
  assign full_scale = {RAW_W{1'b1}} >> shamt;
  assign span_c     = (cfg_i.range_to > cfg_i.range_from) ?
                      (cfg_i.range_to - cfg_i.range_from) : full_scale;
  assign diff_c     = pop_data_i.raw - cfg_i.range_from;

  // one restoring division step
  assign rem2     = {rem_q, 1'b0};
  assign qbit     = (rem2 >= {1'b0, span_q});
  assign quo_next = {quo_q[NORM_W-2:0], qbit};
  assign rnd      = {1'b0, quo_next} + (NORM_W + 1)'(1);

  // rounding add ahead of the final shift
  assign sum_c = PROD_W'(prod_q) + PROD_W'(dmxcv_pkg::ROUND_HALF);

  assign pop_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    raw_d       = raw_q;
    miss_d      = miss_q;
    span_d      = span_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    norm_d      = norm_q;
    delta_d     = delta_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q && !res_out.ready;
    out_raw_d   = out_raw_q;
    out_norm_d  = out_norm_q;
    out_phys_d  = out_phys_q;
    out_miss_d  = out_miss_q;
    unique case (state_q)
      // take a frame and classify it against the range
      ST_IDLE: begin
        if (pop_valid_i) begin
          raw_d   = pop_data_i.raw;
          miss_d  = pop_data_i.missing;
          span_d  = span_c;
          rem_d   = diff_c;
          quo_d   = '0;
          cnt_d   = dmxcv_pkg::DIV_CNT_W'(NORM_W);
          delta_d = $signed({cfg_i.physical_high[PHYS_W-1], cfg_i.physical_high}) -
                    $signed({cfg_i.physical_low[PHYS_W-1], cfg_i.physical_low});
          if (pop_data_i.raw <= cfg_i.range_from) begin
            norm_d  = '0;
            state_d = ST_MUL;
          end else if (diff_c >= span_c) begin
            norm_d  = dmxcv_pkg::NORM_ONE;
            state_d = ST_MUL;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      // one quotient bit per cycle, round half up at the end
      ST_DIV: begin
        rem_d = qbit ? RAW_W'(rem2 - {1'b0, span_q}) : rem2[RAW_W-1:0];
        quo_d = quo_next;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == dmxcv_pkg::DIV_CNT_W'(1)) begin
          norm_d  = rnd[NORM_W:1];
          state_d = ST_MUL;
        end
      end
      // scale the physical span by the position
      ST_MUL: begin
        prod_d  = delta_q * $signed({1'b0, norm_q});
        state_d = ST_SUM;
      end
      // round, offset and load the output register when it is free
      ST_SUM: begin
        if (!out_valid_q || res_out.ready) begin
          out_valid_d = 1'b1;
          out_raw_d   = raw_q;
          out_norm_d  = norm_q;
          out_phys_d  = cfg_i.physical_low + sum_c[dmxcv_pkg::NORM_FRAC +: PHYS_W];
          out_miss_d  = miss_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    raw_q      <= raw_d;
    miss_q     <= miss_d;
    span_q     <= span_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    norm_q     <= norm_d;
    delta_q    <= delta_d;
    prod_q     <= prod_d;
    out_raw_q  <= out_raw_d;
    out_norm_q <= out_norm_d;
    out_phys_q <= out_phys_d;
    out_miss_q <= out_miss_d;
  end

  assign res_out.valid        = out_valid_q;
  assign res_out.raw_word     = out_raw_q;
  assign res_out.normalized   = out_norm_q;
  assign res_out.physical     = $signed(out_phys_q);
  assign res_out.slot_missing = out_miss_q;

endmodule

`default_nettype wire

@@ design/dmx_channel_value_decoder_top.sv @@
// channel    dir  handshake      payload
// slot_in    in   valid/ready    slot_address, slot_value, end_of_frame
// res_out    out  valid/ready    raw_word, normalized, physical, slot_missing
// cfg        in   cfg_we_i       cfg_index_i, cfg_wdata_i
//
// slots are taken one per cycle while the two-entry frame queue has room
// each frame end takes the back end through its multiply and sum states,
// after the bit-serial divider when the value lies strictly inside the range
// a waiting result sits in the output register; the back end then holds
// reset clears capture state, queue, back end control and registers

`default_nettype none

`include "dmx_channel_value_decoder_top_assert.svh"

module dmx_channel_value_decoder_top #(
  parameter int MAX_BYTES = 4
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  dmxcv_slot_if.sink                         slot_in,
  dmxcv_result_if.source                     res_out,
  input  wire                                cfg_we_i,
  input  wire [dmxcv_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire [dmxcv_pkg::CFG_W-1:0]         cfg_wdata_i
);

  logic [dmxcv_pkg::CNT_W-1:0]   byte_count_q;
  logic [dmxcv_pkg::CFG_W-1:0]   sources_q;
  logic [dmxcv_pkg::RAW_W-1:0]   range_from_q;
  logic [dmxcv_pkg::RAW_W-1:0]   range_to_q;
  logic [dmxcv_pkg::PHYS_W-1:0]  phys_low_q;
  logic [dmxcv_pkg::PHYS_W-1:0]  phys_high_q;
  logic [dmxcv_pkg::CNT_W-1:0]   used_bytes;
  dmxcv_pkg::cfg_t               cfg;

  logic                          q_push_valid;
  logic                          q_push_ready;
  dmxcv_pkg::frame_t             q_push_data;
  logic                          q_pop_valid;
  logic                          q_pop_ready;
  dmxcv_pkg::frame_t             q_pop_data;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= dmxcv_pkg::RST_BYTE_COUNT;
      sources_q    <= dmxcv_pkg::RST_SOURCES;
      range_from_q <= dmxcv_pkg::RST_RANGE_FROM;
      range_to_q   <= dmxcv_pkg::RST_RANGE_TO;
      phys_low_q   <= dmxcv_pkg::RST_PHYS_LOW;
      phys_high_q  <= dmxcv_pkg::RST_PHYS_HIGH;
    end else if (cfg_we_i) begin
      unique case (dmxcv_pkg::reg_idx_e'(cfg_index_i))
        dmxcv_pkg::REG_BYTE_COUNT: byte_count_q <= cfg_wdata_i[dmxcv_pkg::CNT_W-1:0];
        dmxcv_pkg::REG_SOURCES:    sources_q    <= cfg_wdata_i;
        dmxcv_pkg::REG_RANGE_FROM: range_from_q <= cfg_wdata_i[dmxcv_pkg::RAW_W-1:0];
        dmxcv_pkg::REG_RANGE_TO:   range_to_q   <= cfg_wdata_i[dmxcv_pkg::RAW_W-1:0];
        dmxcv_pkg::REG_PHYS_LOW:   phys_low_q   <= cfg_wdata_i[dmxcv_pkg::PHYS_W-1:0];
        dmxcv_pkg::REG_PHYS_HIGH:  phys_high_q  <= cfg_wdata_i[dmxcv_pkg::PHYS_W-1:0];
        default: ;
      endcase
    end
  end

  // byte count clamped to 1..MAX_BYTES
  always_comb begin
    if (byte_count_q == '0) begin
      used_bytes = dmxcv_pkg::CNT_W'(1);
    end else if (byte_count_q > dmxcv_pkg::CNT_W'(MAX_BYTES)) begin
      used_bytes = dmxcv_pkg::CNT_W'(MAX_BYTES);
    end else begin
      used_bytes = byte_count_q;
    end
  end

  assign cfg.used_bytes    = used_bytes;
  assign cfg.source_slots  = sources_q;
  assign cfg.range_from    = range_from_q;
  assign cfg.range_to      = range_to_q;
  assign cfg.physical_low  = phys_low_q;
  assign cfg.physical_high = phys_high_q;

  // slot capture and frame assembly
  dmxcv_front #(
    .MAX_BYTES (MAX_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .slot_in      (slot_in),
    .cfg_i        (cfg),
    .push_valid_o (q_push_valid),
    .push_ready_i (q_push_ready),
    .push_data_o  (q_push_data)
  );

  // assembled frames waiting for evaluation
  dmxcv_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_push_valid),
    .push_ready_o (q_push_ready),
    .push_data_i  (q_push_data),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop_ready),
    .pop_data_o   (q_pop_data)
  );

  // normalize and map to physical units
  dmxcv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .pop_valid_i (q_pop_valid),
    .pop_ready_o (q_pop_ready),
    .pop_data_i  (q_pop_data),
    .res_out     (res_out)
  );

  // a frame end transfer is queued by the next cycle
  `DMXCV_ASSERT_NEXT(a_eof_queued, slot_in.valid && slot_in.ready && slot_in.end_of_frame, q_pop_valid)
  // the back end takes at most one frame before it is busy
  `DMXCV_ASSERT_NEXT(a_pop_then_busy, q_pop_valid && q_pop_ready, !q_pop_ready)
  // normalized result never goes above one
  `DMXCV_ASSERT_IMP(a_norm_bounded, res_out.valid, res_out.normalized <= dmxcv_pkg::NORM_ONE)

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  // one decoded channel value as it leaves the block
  typedef struct packed {
    logic [dmxcv_pkg::RAW_W-1:0]  raw;
    logic [dmxcv_pkg::NORM_W-1:0] norm;
    logic [dmxcv_pkg::PHYS_W-1:0] phys;
    logic                         missing;
  } dmx_value_t;

  // mirrors the register file and the slot capture, predicts each frame value
  class decode_tracker;
    logic [dmxcv_pkg::CNT_W-1:0]  byte_count;
    logic [dmxcv_pkg::CFG_W-1:0]  source_slots;
    logic [dmxcv_pkg::RAW_W-1:0]  range_from;
    logic [dmxcv_pkg::RAW_W-1:0]  range_to;
    logic [dmxcv_pkg::PHYS_W-1:0] phys_low;
    logic [dmxcv_pkg::PHYS_W-1:0] phys_high;
    logic [dmxcv_pkg::BYTE_W-1:0] captured [4];
    bit                           seen [4];
    dmx_value_t                   pending_values [$];
    int                           errors;

    function new();
      byte_count   = dmxcv_pkg::RST_BYTE_COUNT;
      source_slots = dmxcv_pkg::RST_SOURCES;
      range_from   = dmxcv_pkg::RST_RANGE_FROM;
      range_to     = dmxcv_pkg::RST_RANGE_TO;
      phys_low     = dmxcv_pkg::RST_PHYS_LOW;
      phys_high    = dmxcv_pkg::RST_PHYS_HIGH;
      errors       = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      foreach (captured[k]) begin
        captured[k] = '0;
        seen[k]     = 1'b0;
      end
    endfunction

    // byte count as the block uses it: zero means one, above four means four
    function int unsigned lanes();
      if (byte_count < 1) return 1;
      if (byte_count > 4) return 4;
      return int'(byte_count);
    endfunction

    function void set_reg(dmxcv_pkg::reg_idx_e idx, logic [dmxcv_pkg::CFG_W-1:0] data);
      case (idx)
        dmxcv_pkg::REG_BYTE_COUNT: byte_count   = data[dmxcv_pkg::CNT_W-1:0];
        dmxcv_pkg::REG_SOURCES:    source_slots = data;
        dmxcv_pkg::REG_RANGE_FROM: range_from   = data[dmxcv_pkg::RAW_W-1:0];
        dmxcv_pkg::REG_RANGE_TO:   range_to     = data[dmxcv_pkg::RAW_W-1:0];
        dmxcv_pkg::REG_PHYS_LOW:   phys_low     = data[dmxcv_pkg::PHYS_W-1:0];
        dmxcv_pkg::REG_PHYS_HIGH:  phys_high    = data[dmxcv_pkg::PHYS_W-1:0];
        default: ;
      endcase
    endfunction

    // pack, normalize and map the captured bytes of one frame
    function dmx_value_t evaluate_frame();
      dmx_value_t                  r;
      int unsigned                 n;
      logic [dmxcv_pkg::RAW_W-1:0] full;
      logic [dmxcv_pkg::RAW_W-1:0] span;
      logic [dmxcv_pkg::RAW_W-1:0] diff;
      longint unsigned             num;
      longint                      delta;
      longint                      prod;
      longint                      scaled;
      n         = lanes();
      r.raw     = '0;
      full      = '0;
      r.missing = 1'b0;
      for (int k = 0; k < n; k++) begin
        r.raw = (r.raw << 8) | {24'b0, (seen[k] ? captured[k] : 8'h00)};
        full  = (full << 8) | 32'hff;
        if (!seen[k]) r.missing = 1'b1;
      end
      span = (range_to > range_from) ? range_to - range_from : full;

      // clamped position in Q1.16, rounded half up
      if (r.raw <= range_from) begin
        r.norm = '0;
      end else begin
        diff = r.raw - range_from;
        if (diff >= span) begin
          r.norm = dmxcv_pkg::NORM_ONE;
        end else begin
          num    = 64'(diff) * 64'd131072 + 64'(span);
          r.norm = dmxcv_pkg::NORM_W'(num / (64'(span) * 64'd2));
        end
      end

      // linear map, rounding toward plus infinity on halves, wraps to 32 bits
      delta  = longint'($signed(phys_high)) - longint'($signed(phys_low));
      prod   = delta * longint'({47'b0, r.norm}) + 64'sd32768;
      scaled = prod >>> 16;
      r.phys = phys_low + scaled[dmxcv_pkg::PHYS_W-1:0];
      return r;
    endfunction

    function void note_slot(logic [dmxcv_pkg::SLOT_W-1:0] addr,
                            logic [dmxcv_pkg::BYTE_W-1:0] val, logic eof);
      int unsigned n;
      n = lanes();
      if (addr < dmxcv_pkg::UNIVERSE_SLOTS) begin
        for (int k = 0; k < n; k++) begin
          if (source_slots[9*k +: 9] == addr) begin
            captured[k] = val;
            seen[k]     = 1'b1;
          end
        end
      end
      if (eof) begin
        pending_values = {pending_values, evaluate_frame()};
        clear_frame();
      end
    endfunction

    function void check_result(dmx_value_t got);
      dmx_value_t want;
      if (pending_values.size() == 0) begin
        $display("%0t: unexpected result, expected none actual raw_word %h", $time, got.raw);
        errors++;
        return;
      end
      want = pending_values.pop_front();
      if (got.raw !== want.raw) begin
        $display("%0t: raw_word expected %h actual %h", $time, want.raw, got.raw);
        errors++;
      end
      if (got.norm !== want.norm) begin
        $display("%0t: normalized expected %h actual %h", $time, want.norm, got.norm);
        errors++;
      end
      if (got.phys !== want.phys) begin
        $display("%0t: physical expected %h actual %h", $time, want.phys, got.phys);
        errors++;
      end
      if (got.missing !== want.missing) begin
        $display("%0t: slot_missing expected %b actual %b", $time, want.missing, got.missing);
        errors++;
      end
    endfunction

    function int pending();
      return pending_values.size();
    endfunction
  endclass

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we;
  logic [dmxcv_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [dmxcv_pkg::CFG_W-1:0]     cfg_wdata;
  bit                              tx_gaps;
  bit                              rx_stalls;
  bit                              rx_hold;
  int                              phase_items;
  decode_tracker                   tracker = new();

  dmxcv_slot_if   slot_ch ();
  dmxcv_result_if res_ch ();

  dmx_channel_value_decoder_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .slot_in     (slot_ch),
    .res_out     (res_ch),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #8_000_000;
    $display("status: fail");
    $finish;
  end

  // result receiver: random stall bursts and one long hold-off on request
  initial begin
    int gap;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold) begin
        res_ch.ready = 1'b0;
        repeat (99) @(negedge clk_i);
        rx_hold = 1'b0;
      end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 7);
        res_ch.ready = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end else begin
        res_ch.ready = 1'b1;
      end
    end
  end

  // check every result transfer
  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready)
      tracker.check_result(dmx_value_t'{res_ch.raw_word, res_ch.normalized,
                                        res_ch.physical, res_ch.slot_missing});
  end

  // register write, called at a falling edge
  task automatic write_reg(dmxcv_pkg::reg_idx_e idx, logic [dmxcv_pkg::CFG_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(posedge clk_i);
    tracker.set_reg(idx, data);
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  // one slot transfer, called at a falling edge, returns at a falling edge
  task automatic send_slot(logic [dmxcv_pkg::SLOT_W-1:0] addr,
                           logic [dmxcv_pkg::BYTE_W-1:0] val, logic eof);
    int gap;
    if (tx_gaps && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 7);
      slot_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    slot_ch.valid        = 1'b1;
    slot_ch.slot_address = addr;
    slot_ch.slot_value   = val;
    slot_ch.end_of_frame = eof;
    do @(posedge clk_i); while (!slot_ch.ready);
    tracker.note_slot(addr, val, eof);
    phase_items++;
    @(negedge clk_i);
  endtask

  // stop sending and wait until every frame value has come out
  task automatic wait_drained();
    slot_ch.valid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  function automatic logic [dmxcv_pkg::BYTE_W-1:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return dmxcv_pkg::BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [dmxcv_pkg::RAW_W-1:0] rand_range(
      logic [dmxcv_pkg::RAW_W-1:0] full);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return full;
      2:       return 32'hffff_ffff;
      3:       return full >> 1;
      default: return $urandom_range(0, full);
    endcase
  endfunction

  function automatic logic [dmxcv_pkg::PHYS_W-1:0] rand_phys();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return 32'h0001_0000;
      default: return $urandom;
    endcase
  endfunction

  // new settings for a phase; the first two pin the range and map extremes
  task automatic configure_phase(int p);
    logic [dmxcv_pkg::CNT_W-1:0]  bc;
    int unsigned                  n;
    logic [dmxcv_pkg::RAW_W-1:0]  full;
    logic [dmxcv_pkg::CFG_W-1:0]  src;
    logic [dmxcv_pkg::RAW_W-1:0]  from_v;
    logic [dmxcv_pkg::RAW_W-1:0]  to_v;
    logic [dmxcv_pkg::PHYS_W-1:0] low_v;
    logic [dmxcv_pkg::PHYS_W-1:0] high_v;
    bc   = dmxcv_pkg::CNT_W'($urandom_range(0, 7));
    if (p == 0) bc = 3'd4;
    if (p == 1) bc = 3'd1;
    n    = (bc == 0) ? 1 : (bc > 4) ? 4 : int'(bc);
    full = (n == 4) ? 32'hffff_ffff : (32'h1 << (8 * n)) - 32'h1;
    src  = '0;
    for (int k = 0; k < 4; k++) begin
      // now and then two fields name the same slot
      if (k > 0 && $urandom_range(0, 7) == 0) src[9*k +: 9] = src[8:0];
      else src[9*k +: 9] = dmxcv_pkg::SLOT_W'($urandom_range(0, 511));
    end
    from_v = rand_range(full);
    to_v   = rand_range(full);
    low_v  = rand_phys();
    high_v = rand_phys();
    if (p == 0) begin
      from_v = '0;
      to_v   = 32'hffff_ffff;
      low_v  = 32'h8000_0000;
      high_v = 32'h7fff_ffff;
    end else if (p == 1) begin
      from_v = '0;
      to_v   = '0;
      low_v  = 32'h7fff_ffff;
      high_v = 32'h8000_0000;
    end
    write_reg(dmxcv_pkg::REG_BYTE_COUNT, dmxcv_pkg::CFG_W'(bc));
    write_reg(dmxcv_pkg::REG_SOURCES, src);
    write_reg(dmxcv_pkg::REG_RANGE_FROM, dmxcv_pkg::CFG_W'(from_v));
    write_reg(dmxcv_pkg::REG_RANGE_TO, dmxcv_pkg::CFG_W'(to_v));
    write_reg(dmxcv_pkg::REG_PHYS_LOW, dmxcv_pkg::CFG_W'(low_v));
    write_reg(dmxcv_pkg::REG_PHYS_HIGH, dmxcv_pkg::CFG_W'(high_v));
  endtask

  // one frame: mostly every used source slot with noise between, else a random mix
  task automatic send_frame();
    int unsigned                 n;
    int unsigned                 len;
    logic [dmxcv_pkg::SLOT_W-1:0] src [4];
    logic [dmxcv_pkg::SLOT_W-1:0] addr;
    n = tracker.lanes();
    for (int k = 0; k < 4; k++) src[k] = tracker.source_slots[9*k +: 9];
    if ($urandom_range(0, 9) < 7) begin
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 3) == 0)
          send_slot(dmxcv_pkg::SLOT_W'($urandom_range(0, 511)), rand_byte(), 1'b0);
        send_slot(src[k], rand_byte(), 1'b0);
      end
    end else begin
      len = $urandom_range(0, 5);
      repeat (len) begin
        addr = $urandom_range(0, 1) ? src[$urandom_range(0, 3)]
                                    : dmxcv_pkg::SLOT_W'($urandom_range(0, 511));
        send_slot(addr, rand_byte(), 1'b0);
      end
    end
    addr = $urandom_range(0, 1) ? src[$urandom_range(0, n - 1)]
                                : dmxcv_pkg::SLOT_W'($urandom_range(0, 511));
    send_slot(addr, rand_byte(), 1'b1);
  endtask

  // stimulus
  initial begin
    rst_ni               = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = dmxcv_pkg::REG_BYTE_COUNT;
    cfg_wdata            = '0;
    slot_ch.valid        = 1'b0;
    slot_ch.slot_address = '0;
    slot_ch.slot_value   = '0;
    slot_ch.end_of_frame = 1'b0;
    tx_gaps              = 1'b0;
    rx_stalls            = 1'b0;
    rx_hold              = 1'b0;
    phase_items          = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: one byte from slot 0, range 0..255 mapped to 0..1.0
    send_slot(9'd0, 8'h00, 1'b1);
    send_slot(9'd0, 8'hff, 1'b1);
    send_slot(9'd0, 8'h80, 1'b1);
    // source slot absent
    send_slot(9'd7, 8'h09, 1'b1);
    // repeated slot, latest value wins
    send_slot(9'd0, 8'h05, 1'b0);
    send_slot(9'd0, 8'h4d, 1'b0);
    send_slot(9'd3, 8'h01, 1'b1);
    send_slot(9'd0, 8'h01, 1'b0);
    send_slot(9'd1, 8'h02, 1'b1);
    wait_drained();

    // byte count above four, two fields on one slot, empty range, widest map
    write_reg(dmxcv_pkg::REG_BYTE_COUNT, dmxcv_pkg::CFG_W'(7));
    write_reg(dmxcv_pkg::REG_SOURCES, {9'd511, 9'd12, 9'd300, 9'd300});
    write_reg(dmxcv_pkg::REG_RANGE_FROM, dmxcv_pkg::CFG_W'(16));
    write_reg(dmxcv_pkg::REG_RANGE_TO, dmxcv_pkg::CFG_W'(16));
    write_reg(dmxcv_pkg::REG_PHYS_LOW, dmxcv_pkg::CFG_W'(32'h8000_0000));
    write_reg(dmxcv_pkg::REG_PHYS_HIGH, dmxcv_pkg::CFG_W'(32'h7fff_ffff));
    send_slot(9'd300, 8'hab, 1'b0);
    send_slot(9'd12, 8'h00, 1'b0);
    send_slot(9'd511, 8'hff, 1'b1);
    send_slot(9'd12, 8'h80, 1'b1);
    wait_drained();

    // byte count zero, range start above every raw value
    write_reg(dmxcv_pkg::REG_BYTE_COUNT, dmxcv_pkg::CFG_W'(0));
    write_reg(dmxcv_pkg::REG_RANGE_FROM, dmxcv_pkg::CFG_W'(32'hffff_ffff));
    write_reg(dmxcv_pkg::REG_RANGE_TO, dmxcv_pkg::CFG_W'(0));
    send_slot(9'd300, 8'hc8, 1'b1);
    send_slot(9'd5, 8'h11, 1'b1);
    wait_drained();

    // random phases; the third holds the receiver off, the last runs flat out
    for (int p = 0; p < 12; p++) begin
      configure_phase(p);
      tx_gaps     = (p < 11) && (p % 4 != 3);
      rx_stalls   = (p < 11) && (p % 4 != 3);
      rx_hold     = (p == 2);
      phase_items = 0;
      while (phase_items < 55) send_frame();
      wait_drained();
    end

    if (tracker.errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
